// File: design/dsjc_pkg.sv
// Package for the dual servo jog controller: types, codes, constants and the pulse function.
`default_nettype none
package dsjc_pkg;

  // Field widths
  localparam int unsigned FuncW   = 2;
  localparam int unsigned KeyW    = 8;
  localparam int unsigned AngleW  = 8;
  localparam int unsigned StepW   = 6;
  localparam int unsigned GuardW  = 10;
  localparam int unsigned PulseW  = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 48;

  // Reset values of the configuration registers
  localparam logic [GuardW-1:0] GuardMsRst   = 10'd300;
  localparam logic [AngleW-1:0] LimitOneRst  = 8'd180;
  localparam logic [AngleW-1:0] LimitTwoRst  = 8'd110;
  localparam logic [StepW-1:0]  StepUnitRst  = 6'd5;
  localparam logic [StepW-1:0]  StepLimitRst = 6'd40;

  // Angle constants
  localparam logic [AngleW-1:0] AngleMax    = 8'd180;
  localparam logic [AngleW-1:0] AngleCenter = 8'd90;
  localparam logic [StepW-1:0]  StepRst     = 6'd5;

  // Pulse: 250 + angle*50/9, the divide by 9 done as *7282 >> 16 (exact for angle <= 255)
  localparam int unsigned PulseBase  = 250;
  localparam int unsigned PulseRecip = 50 * 7282;
  localparam int unsigned ProdW      = 27;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GUARD_MS   = 3'd0,
    CFG_LIMIT_ONE  = 3'd1,
    CFG_LIMIT_TWO  = 3'd2,
    CFG_STEP_UNIT  = 3'd3,
    CFG_STEP_LIMIT = 3'd4
  } cfg_idx_e;

  // Function codes of an input item
  typedef enum logic [FuncW-1:0] {
    FUNC_KEY   = 2'd0,
    FUNC_ENTER = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  // Key codes
  localparam logic [KeyW-1:0] KeyOneDown = 8'h34; // '4'
  localparam logic [KeyW-1:0] KeyOneUp   = 8'h36; // '6'
  localparam logic [KeyW-1:0] KeyTwoDown = 8'h32; // '2'
  localparam logic [KeyW-1:0] KeyTwoUp   = 8'h38; // '8'
  localparam logic [KeyW-1:0] KeyStepUp  = 8'h2B; // '+'
  localparam logic [KeyW-1:0] KeyStepDn  = 8'h2D; // '-'
  localparam logic [KeyW-1:0] KeyExit    = 8'h6E; // 'n'

  typedef struct packed {
    logic [GuardW-1:0] guard_ms;
    logic [AngleW-1:0] limit_one;
    logic [AngleW-1:0] limit_two;
    logic [StepW-1:0]  step_unit;
    logic [StepW-1:0]  step_limit;
  } cfg_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [KeyW-1:0]  key_code;
  } item_t;

  typedef struct packed {
    logic              exit_request;
    logic [StepW-1:0]  step_size;
    logic [AngleW-1:0] angle_two;
    logic [AngleW-1:0] angle_one;
    logic [PulseW-1:0] pulse_two;
    logic [PulseW-1:0] pulse_one;
  } result_t;

  // Timer compare value for an angle
  function automatic logic [PulseW-1:0] pulse_of(input logic [AngleW-1:0] angle);
    logic [ProdW-1:0] prod;
    prod = ProdW'(angle) * ProdW'(PulseRecip);
    return PulseW'(PulseBase) + prod[ProdW-1:16];
  endfunction

endpackage
`default_nettype wire

// File: design/dual_servo_jog_controller.sv
// A request accepted into the input register moves on into the result register, offered on the
// master side, once that register is empty or being read by the master side.
// Throughput: one request per cycle without master stalls; the single-pass jog update sets that figure.
// Stalls on the master side back up through the two registers; no request is dropped.
// Reset (rst_ni low, asynchronous): both angles 90, step 5, guard count 0, inactive,
// configuration registers at their defaults, both stages empty.
`default_nettype none
module dual_servo_jog_controller (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output      logic                              s_axis_tready_o,
  input  wire logic [dsjc_pkg::InDataW-1:0]      s_axis_tdata_i,  // key_code[7:0]
  input  wire logic [dsjc_pkg::FuncW-1:0]        s_axis_tuser_i,  // func[1:0]
  output      logic                              m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // pulse_one[10:0], pulse_two[21:11], angle_one[29:22], angle_two[37:30],
  // step_size[43:38], exit_request[44], zero fill[47:45]
  output      logic [dsjc_pkg::OutDataW-1:0]     m_axis_tdata_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [dsjc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [dsjc_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  dsjc_pkg::cfg_t    cfg;
  dsjc_pkg::item_t   item_q;
  dsjc_pkg::result_t result, result_q;
  logic              in_valid_q, out_valid_q;
  logic              advance;

  dsjc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake between the two stages
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      item_q.func     <= s_axis_tuser_i;
      item_q.key_code <= s_axis_tdata_i;
    end
  end

  dsjc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item_q),
    .fire_i   (advance),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) result_q <= result;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, result_q};

  // Checks
  a_full_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("request taken while both stages are stalled");

  a_angles_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (result_q.angle_one <= dsjc_pkg::AngleMax &&
                         result_q.angle_two <= dsjc_pkg::AngleMax))
    else $error("servo angle above 180");

  a_pulse_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (result_q.pulse_one >= 11'd250 && result_q.pulse_one <= 11'd1250 &&
                         result_q.pulse_two >= 11'd250 && result_q.pulse_two <= 11'd1250))
    else $error("pulse compare value out of range");

  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (result_q.step_size != '0))
    else $error("jog step is zero");

endmodule
`default_nettype wire

// File: design/dsjc_cfg_regs.sv
// Configuration register file of the dual servo jog controller.
`default_nettype none
module dsjc_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dsjc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [dsjc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output dsjc_pkg::cfg_t                        cfg_o
);

  dsjc_pkg::cfg_t cfg_q, cfg_d;

  // Decode writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        dsjc_pkg::CFG_GUARD_MS:   cfg_d.guard_ms   = cfg_wdata_i[dsjc_pkg::GuardW-1:0];
        dsjc_pkg::CFG_LIMIT_ONE:  cfg_d.limit_one  = cfg_wdata_i[dsjc_pkg::AngleW-1:0];
        dsjc_pkg::CFG_LIMIT_TWO:  cfg_d.limit_two  = cfg_wdata_i[dsjc_pkg::AngleW-1:0];
        dsjc_pkg::CFG_STEP_UNIT:  cfg_d.step_unit  = cfg_wdata_i[dsjc_pkg::StepW-1:0];
        dsjc_pkg::CFG_STEP_LIMIT: cfg_d.step_limit = cfg_wdata_i[dsjc_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.guard_ms   <= dsjc_pkg::GuardMsRst;
      cfg_q.limit_one  <= dsjc_pkg::LimitOneRst;
      cfg_q.limit_two  <= dsjc_pkg::LimitTwoRst;
      cfg_q.step_unit  <= dsjc_pkg::StepUnitRst;
      cfg_q.step_limit <= dsjc_pkg::StepLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: design/dsjc_core.sv
// Jog state and single-pass update logic of the dual servo jog controller.
`default_nettype none
module dsjc_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dsjc_pkg::cfg_t    cfg_i,
  input  wire dsjc_pkg::item_t   item_i,
  input  wire logic              fire_i,
  output dsjc_pkg::result_t      result_o
);

  logic [dsjc_pkg::AngleW-1:0] one_q, one_d, two_q, two_d;
  logic [dsjc_pkg::StepW-1:0]  step_q, step_d;
  logic [dsjc_pkg::GuardW-1:0] guard_q, guard_d;
  logic                        active_q, active_d;
  logic                        exit_req;

  logic [dsjc_pkg::StepW-1:0]  unit_eff, step_ceil, step_dn;
  logic [dsjc_pkg::AngleW-1:0] ceil_one, ceil_two;
  logic [dsjc_pkg::AngleW:0]   one_up, two_up;
  logic [dsjc_pkg::StepW:0]    step_up, two_unit;
  logic                        keys_on;

  // Effective limits
  assign unit_eff  = (cfg_i.step_unit == '0) ? dsjc_pkg::StepW'(1) : cfg_i.step_unit;
  assign step_ceil = (cfg_i.step_limit < unit_eff) ? unit_eff : cfg_i.step_limit;
  assign ceil_one  = (cfg_i.limit_one > dsjc_pkg::AngleMax) ? dsjc_pkg::AngleMax
                                                             : cfg_i.limit_one;
  assign ceil_two  = (cfg_i.limit_two > dsjc_pkg::AngleMax) ? dsjc_pkg::AngleMax
                                                             : cfg_i.limit_two;

  // Candidate sums
  assign one_up   = {1'b0, one_q} + {3'b000, step_q};
  assign two_up   = {1'b0, two_q} + {3'b000, step_q};
  assign step_up  = {1'b0, step_q} + {1'b0, unit_eff};
  assign two_unit = {unit_eff, 1'b0};
  assign step_dn  = ({1'b0, step_q} >= two_unit) ? (step_q - unit_eff) : unit_eff;

  assign keys_on = active_q && (guard_q >= cfg_i.guard_ms);

  // Next state for the current item
  always_comb begin
    one_d    = one_q;
    two_d    = two_q;
    step_d   = step_q;
    guard_d  = guard_q;
    active_d = active_q;
    exit_req = 1'b0;
    case (item_i.func)
      dsjc_pkg::FUNC_ENTER: begin
        one_d    = dsjc_pkg::AngleCenter;
        two_d    = dsjc_pkg::AngleCenter;
        step_d   = unit_eff;
        guard_d  = '0;
        active_d = 1'b1;
      end
      dsjc_pkg::FUNC_TICK: begin
        if (guard_q < cfg_i.guard_ms) guard_d = guard_q + 1'b1;
      end
      dsjc_pkg::FUNC_KEY: begin
        if (keys_on) begin
          case (item_i.key_code)
            dsjc_pkg::KeyOneDown: one_d = (one_q >= {2'b00, step_q}) ? one_q - {2'b00, step_q}
                                                                    : '0;
            dsjc_pkg::KeyOneUp:   one_d = (one_up <= {1'b0, ceil_one}) ? one_up[7:0] : ceil_one;
            dsjc_pkg::KeyTwoDown: two_d = (two_q >= {2'b00, step_q}) ? two_q - {2'b00, step_q}
                                                                    : '0;
            dsjc_pkg::KeyTwoUp:   two_d = (two_up <= {1'b0, ceil_two}) ? two_up[7:0] : ceil_two;
            dsjc_pkg::KeyStepUp:  step_d = (step_up > {1'b0, step_ceil}) ? step_ceil
                                                                          : step_up[5:0];
            dsjc_pkg::KeyStepDn:  step_d = (step_dn > step_ceil) ? step_ceil : step_dn;
            dsjc_pkg::KeyExit: begin
              exit_req = 1'b1;
              active_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // State registers, updated when the item moves to the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_q    <= dsjc_pkg::AngleCenter;
      two_q    <= dsjc_pkg::AngleCenter;
      step_q   <= dsjc_pkg::StepRst;
      guard_q  <= '0;
      active_q <= 1'b0;
    end else if (fire_i) begin
      one_q    <= one_d;
      two_q    <= two_d;
      step_q   <= step_d;
      guard_q  <= guard_d;
      active_q <= active_d;
    end
  end

  // Result from the updated state
  assign result_o.pulse_one    = dsjc_pkg::pulse_of(one_d);
  assign result_o.pulse_two    = dsjc_pkg::pulse_of(two_d);
  assign result_o.angle_one    = one_d;
  assign result_o.angle_two    = two_d;
  assign result_o.step_size    = step_d;
  assign result_o.exit_request = exit_req;

endmodule
`default_nettype wire
